// ===== rtl/core/eav_pkg.sv =====
// Package for the email address validator: character classes, scan phases,
// scan state and the constants used to classify code units. No dependencies.
package eav_pkg;

  localparam int UNIT_W     = 16;
  localparam int CHAR_WIDTH = 16;
  localparam int N_SPECIALS = 12;

  typedef logic [UNIT_W-1:0]     unit_t;
  typedef logic [CHAR_WIDTH-1:0] char_t;

  localparam char_t U_DOT    = char_t'(8'h2E);
  localparam char_t U_QUOTE  = char_t'(8'h22);
  localparam char_t U_BSLASH = char_t'(8'h5C);
  localparam char_t U_SPACE  = char_t'(8'h20);
  localparam char_t U_DEL    = char_t'(8'h7F);
  localparam char_t U_AT     = char_t'(8'h40);

  localparam char_t SPECIALS [N_SPECIALS] = '{
    char_t'(8'h28), char_t'(8'h29), char_t'(8'h3C), char_t'(8'h3E),
    char_t'(8'h40), char_t'(8'h2C), char_t'(8'h3B), char_t'(8'h3A),
    char_t'(8'h5C), char_t'(8'h22), char_t'(8'h5B), char_t'(8'h5D)
  };

  typedef enum logic [2:0] {
    PH_LSTART,
    PH_LOCAL,
    PH_QUOTED,
    PH_ESCAPE,
    PH_DSTART,
    PH_DOMAIN
  } phase_t;

  typedef struct packed {
    logic is_dot;
    logic is_quote;
    logic is_bslash;
    logic is_space;
    logic is_at;
    logic printable;
    logic special;
  } unit_class_t;

  typedef struct packed {
    phase_t phase;
    logic   prev_was_dot;
    logic   prev_was_quote;
    logic   domain_dot_seen;
    logic   failed;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase: PH_LSTART, prev_was_dot: 1'b0, prev_was_quote: 1'b0,
    domain_dot_seen: 1'b0, failed: 1'b0
  };

endpackage

// ===== rtl/core/eav_unit_if.sv =====
// Input channel of the email address validator: one code unit per transfer.
// Depends on eav_pkg.
interface eav_unit_if;
  import eav_pkg::*;

  logic  valid;
  logic  ready;
  unit_t code_unit;
  logic  last;

  modport source (output valid, output code_unit, output last, input ready);
  modport sink   (input valid, input code_unit, input last, output ready);
endinterface

// ===== rtl/core/eav_verdict_if.sv =====
// Output channel of the email address validator: one verdict per address.
// No dependencies.
interface eav_verdict_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

// ===== rtl/core/eav_classify.sv =====
// Code unit classifier: flags dot, quote, backslash, space, '@', printable
// and special. Depends on eav_pkg.
module eav_classify (
  input  eav_pkg::unit_t       code_unit,
  output eav_pkg::unit_class_t cls
);
  import eav_pkg::*;

  char_t u;
  logic  spec;

  assign u = code_unit[CHAR_WIDTH-1:0];

  always_comb begin
    spec = 1'b0;
    for (int i = 0; i < N_SPECIALS; i++) begin
      spec = spec | (u == SPECIALS[i]);
    end
  end

  always_comb begin
    cls.is_dot    = (u == U_DOT);
    cls.is_quote  = (u == U_QUOTE);
    cls.is_bslash = (u == U_BSLASH);
    cls.is_space  = (u == U_SPACE);
    cls.is_at     = (u == U_AT);
    cls.printable = (u > U_SPACE) && (u < U_DEL);
    cls.special   = spec;
  end
endmodule

// ===== rtl/core/eav_scan.sv =====
// Address scanner: phase register and flags, updated once per code unit,
// with the verdict formed on the last unit. Depends on eav_pkg.
module eav_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 step_last,
  input  eav_pkg::unit_class_t cls,
  output logic                 verdict
);
  import eav_pkg::*;

  scan_state_t state;
  scan_state_t state_next;
  scan_state_t upd;
  logic        plain;

  assign plain = cls.printable && !cls.special;

  always_comb begin
    upd = state;
    if (!state.failed) begin
      unique case (state.phase)
        PH_LSTART, PH_LOCAL: begin
          priority if (state.prev_was_quote) begin
            upd.prev_was_quote = 1'b0;
            priority if (cls.is_at) begin
              upd.phase        = PH_DSTART;
              upd.prev_was_dot = 1'b0;
            end else if (cls.is_dot) begin
              upd.phase        = PH_LOCAL;
              upd.prev_was_dot = 1'b1;
            end else begin
              upd.failed = 1'b1;
            end
          end else if (cls.is_quote &&
                       (state.phase == PH_LSTART || state.prev_was_dot)) begin
            upd.phase        = PH_QUOTED;
            upd.prev_was_dot = 1'b0;
          end else if (cls.is_at) begin
            if (state.phase == PH_LSTART || state.prev_was_dot) begin
              upd.failed = 1'b1;
            end else begin
              upd.phase        = PH_DSTART;
              upd.prev_was_dot = 1'b0;
            end
          end else if (state.phase == PH_LSTART && cls.is_dot) begin
            upd.failed = 1'b1;
          end else if (!plain) begin
            upd.failed = 1'b1;
          end else begin
            upd.phase        = PH_LOCAL;
            upd.prev_was_dot = cls.is_dot;
          end
        end
        PH_QUOTED: begin
          priority if (cls.is_quote) begin
            upd.phase          = PH_LOCAL;
            upd.prev_was_quote = 1'b1;
            upd.prev_was_dot   = 1'b0;
          end else if (cls.is_bslash) begin
            upd.phase = PH_ESCAPE;
          end else if (!cls.printable) begin
            upd.failed = 1'b1;
          end else begin
            upd.phase = PH_QUOTED;
          end
        end
        PH_ESCAPE: begin
          if (cls.is_space || cls.printable) begin
            upd.phase = PH_QUOTED;
          end else begin
            upd.failed = 1'b1;
          end
        end
        PH_DSTART: begin
          if (cls.is_dot || !plain) begin
            upd.failed = 1'b1;
          end else begin
            upd.phase        = PH_DOMAIN;
            upd.prev_was_dot = 1'b0;
          end
        end
        PH_DOMAIN: begin
          priority if (cls.is_dot) begin
            if (state.prev_was_dot) begin
              upd.failed = 1'b1;
            end else begin
              upd.domain_dot_seen = 1'b1;
              upd.prev_was_dot    = 1'b1;
            end
          end else if (!plain) begin
            upd.failed = 1'b1;
          end else begin
            upd.prev_was_dot = 1'b0;
          end
        end
        default: begin
          upd.failed = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    if (step) begin
      state_next = step_last ? SCAN_RESET : upd;
    end
  end

  always_comb begin
    verdict = !upd.failed && (upd.phase == PH_DOMAIN) && upd.domain_dot_seen &&
              !upd.prev_was_dot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_RESET;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ===== rtl/core/email_address_validator_core.sv =====
// Email address validator: input register, classifier and scanner, verdict register.
// A last code unit's verdict is formed from the input register and held in the verdict register.
// Throughput: one code unit per cycle; only a last unit waits for a full verdict register.
// Reset (rst, synchronous): empties both registers and returns the scanner to local part start.
// Depends on eav_pkg, eav_unit_if, eav_verdict_if, eav_classify, eav_scan.
module email_address_validator_core (
  input  logic          clk,
  input  logic          rst,
  eav_unit_if.sink      units,
  eav_verdict_if.source verdict
);
  import eav_pkg::*;

  logic        in_v;
  unit_t       in_unit;
  logic        in_last;
  logic        out_v;
  logic        out_res;
  logic        adv;
  logic        scan_ok;
  unit_class_t cls;

  assign adv           = in_v && (!in_last || !out_v || verdict.ready);
  assign units.ready   = !in_v || adv;
  assign verdict.valid = out_v;
  assign verdict.valid_res = out_res;

  eav_classify u_classify (
    .code_unit (in_unit),
    .cls       (cls)
  );

  eav_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .step_last (in_last),
    .cls       (cls),
    .verdict   (scan_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (units.ready) begin
      in_v <= units.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (units.ready && units.valid) begin
      in_unit <= units.code_unit;
      in_last <= units.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv && in_last) begin
      out_v <= 1'b1;
    end else if (verdict.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last) begin
      out_res <= scan_ok;
    end
  end
endmodule

// ===== rtl/core/eav_checker.sv =====
// Port-level checks for email_address_validator_core, attached by bind.
// Depends on email_address_validator_core.
module eav_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_res
);
  logic in_xfer_last;

  assign in_xfer_last = in_valid && in_ready && in_last;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("stalled verdict changed or dropped");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled verdict");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    in_xfer_last ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("last transfer gave no verdict");
endmodule

bind email_address_validator_core eav_checker u_eav_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (units.valid),
  .in_ready  (units.ready),
  .in_last   (units.last),
  .out_valid (verdict.valid),
  .out_ready (verdict.ready),
  .out_res   (verdict.valid_res)
);
